// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and byte encoding helpers for the UTF-16 to UTF-8 core.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [5:0]     HighTag = 6'b110110;
	localparam logic [5:0]     LowTag  = 6'b110111;
	localparam logic [CpW-1:0] CpRepl  = 21'h00fffd;
	localparam logic [10:0]    SuppOfs = 11'd64;   // 0x10000 >> 10

	// byte count minus one
	typedef enum logic [1:0] {
		LEN1 = 2'd0,
		LEN2 = 2'd1,
		LEN3 = 2'd2,
		LEN4 = 2'd3
	} cp_len_t;

	// one queue entry per input word that produces output
	typedef struct packed {
		logic           str_end;   // word was last of string
		logic           has_cp;    // encode cp
		logic           pre_repl;  // emit U+FFFD before cp
		cp_len_t        len;
		logic [CpW-1:0] cp;
	} u16u8_entry_t;

	function automatic cp_len_t cp_len(input logic [CpW-1:0] cp);
		cp_len_t l;
		if (cp < 21'h80) begin
			l = LEN1;
		end else if (cp < 21'h800) begin
			l = LEN2;
		end else if (cp < 21'h10000) begin
			l = LEN3;
		end else begin
			l = LEN4;
		end
		return l;
	endfunction

	// byte k (0 = lead) of the encoding of cp with the given length
	function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp, input cp_len_t len,
			input logic [1:0] k);
		logic [7:0] b;
		logic [1:0] j;
		j = 2'(len) - k;
		if (k == 2'd0) begin
			case (len)
				LEN1:    b = {1'b0, cp[6:0]};
				LEN2:    b = {3'b110, cp[10:6]};
				LEN3:    b = {4'b1110, cp[15:12]};
				LEN4:    b = {5'b11110, cp[20:18]};
				default: b = 8'h00;
			endcase
		end else begin
			case (j)
				2'd0:    b = {2'b10, cp[5:0]};
				2'd1:    b = {2'b10, cp[11:6]};
				2'd2:    b = {2'b10, cp[17:12]};
				default: b = 8'h80;
			endcase
		end
		return b;
	endfunction

	function automatic logic [7:0] repl_byte(input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = 8'hef;
			2'd1:    b = 8'hbf;
			default: b = 8'hbd;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and queues one code point job per word that produces output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [15:0]              code_unit,
	input  logic                     last_unit,
	input  logic                     q_full,
	output logic                     q_push,
	output u16u8_pkg::u16u8_entry_t  q_entry
);
	import u16u8_pkg::*;

	logic       held_valid_q;
	logic [9:0] held_high_q;
	logic       accept, is_high, is_low, pair;
	logic [CpW-1:0] cp;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_high  = code_unit[15:10] == HighTag;
	assign is_low   = code_unit[15:10] == LowTag;
	assign pair     = held_valid_q && is_low;

	always_comb begin
		if (pair) begin
			cp = {{1'b0, held_high_q} + SuppOfs, code_unit[9:0]};
		end else if (is_high || is_low) begin
			cp = CpRepl;
		end else begin
			cp = CpW'(code_unit);
		end
		q_entry.cp       = cp;
		q_entry.len      = cp_len(cp);
		q_entry.pre_repl = held_valid_q && !is_low;
		q_entry.has_cp   = !is_high || last_unit;
		q_entry.str_end  = last_unit;
		q_push           = accept && (q_entry.pre_repl || q_entry.has_cp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_high_q  <= '0;
		end else if (accept) begin
			held_valid_q <= is_high && !last_unit;
			held_high_q  <= (is_high && !last_unit) ? code_unit[9:0] : 10'd0;
		end
	end

	`ASSERT_CLK(a_end_clears_held, (accept && last_unit) |=> !held_valid_q,
		"surrogate still held after end of string")

endmodule

// ===== rtl/u16u8_fifo.sv =====
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short register queue between front and back, first word fall-through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  u16u8_pkg::u16u8_entry_t  push_data,
	output logic                     full,
	input  logic                     pop,
	output logic                     head_valid,
	output u16u8_pkg::u16u8_entry_t  head
);
	import u16u8_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	u16u8_entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_push_full, push && full && !pop, "push into full queue")

endmodule

// ===== rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Takes queued code point jobs and sends their UTF-8 bytes one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  u16u8_pkg::u16u8_entry_t  q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_byte,
	output logic                     run_end,
	output logic                     string_end
);
	import u16u8_pkg::*;

	u16u8_entry_t cur_q;
	logic         cur_valid_q;
	logic [2:0]   idx_q;
	logic         out_valid_q, run_end_q, str_end_q;
	logic [7:0]   byte_q;

	logic       adv, emit, last_b, in_repl;
	logic [2:0] last_idx;
	logic [1:0] k;
	logic [7:0] nxt_byte;

	always_comb begin
		adv      = !out_valid_q || out_ready;
		emit     = cur_valid_q && adv;
		last_idx = (cur_q.pre_repl ? 3'd3 : 3'd0) + (cur_q.has_cp ? {1'b0, cur_q.len} : 3'd7);
		last_b   = idx_q == last_idx;
		in_repl  = cur_q.pre_repl && (idx_q < 3'd3);
		k        = cur_q.pre_repl ? 2'(idx_q - 3'd3) : idx_q[1:0];
		nxt_byte = in_repl ? repl_byte(idx_q[1:0]) : utf8_byte(cur_q.cp, cur_q.len, k);
		q_pop    = q_valid && (!cur_valid_q || (emit && last_b));
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			byte_q    <= nxt_byte;
			run_end_q <= last_b;
			str_end_q <= last_b && cur_q.str_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				cur_valid_q <= !last_b;
				idx_q       <= idx_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign run_end    = run_end_q;
	assign string_end = str_end_q;

	`ASSERT_NEVER(a_empty_job, cur_valid_q && !cur_q.pre_repl && !cur_q.has_cp,
		"job with no bytes")
	`ASSERT_CLK(a_strend_runend, out_valid_q && str_end_q |-> run_end_q,
		"string end on a byte that does not end its word")

endmodule

// ===== rtl/utf16_to_utf8_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// UTF-16 code units in, UTF-8 bytes out, surrogate pairing and U+FFFD repair.
// ----------------------------------------------------------------------------
// A word's job passes the queue, the job register and the output byte register.
// Throughput: one byte per cycle while m_axis_tready allows; a word yields
// 1 to 6 bytes (none for a held high surrogate), paced by the byte sequencer.
// Words are taken every cycle while the FIFO_DEPTH entry job queue has room.
// Reset (arst_n low) clears the held surrogate, the queue and the output valid.
module utf16_to_utf8_transcoder_core #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  logic        s_axis_tlast,   // last_unit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tuser,   // [0] run_end
	output logic        m_axis_tlast    // string_end
);
	import u16u8_pkg::*;

	u16u8_entry_t push_entry, head_entry;
	logic push, full, pop, head_valid;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.code_unit (s_axis_tdata),
		.last_unit (s_axis_tlast),
		.q_full    (full),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	u16u8_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head_entry)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (head_valid),
		.q_head     (head_entry),
		.q_pop      (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_end    (m_axis_tuser),
		.string_end (m_axis_tlast)
	);

endmodule
